/* src/tkst_pkg.sv */
// Package for the top-k score table: entry type, request codes and cell operations.
// It depends on nothing; the cells and the top level use it.
package tkst_pkg;

   typedef struct packed {
      logic [15:0] score;
      logic [31:0] name;
   } entry_type;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_OFFER = 2'd1,
      REQ_SHOW  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

endpackage

/* src/tkst_cell.sv */
// One cell of the sorted chain: it holds one entry and either keeps it, takes part
// in an ordered insertion, or rotates toward the head. It depends on tkst_pkg.
module tkst_cell (
   input  logic                  clock,
   input  tkst_pkg::cell_op_type op,
   input  tkst_pkg::entry_type   new_entry,
   input  tkst_pkg::entry_type   up_entry,
   input  logic                  up_ge,
   input  tkst_pkg::entry_type   dn_entry,
   input  logic                  occupied,
   output tkst_pkg::entry_type   entry,
   output logic                  ge
);

   tkst_pkg::entry_type entry_ff;
   tkst_pkg::entry_type entry_in;

   assign ge    = occupied && (entry_ff.score >= new_entry.score);
   assign entry = entry_ff;

   always_comb begin
      unique case (op)
         tkst_pkg::CELL_INSERT: begin
            if (ge) begin
               entry_in = entry_ff;
            end else if (up_ge) begin
               entry_in = new_entry;
            end else begin
               entry_in = up_entry;
            end
         end
         tkst_pkg::CELL_ROTATE: begin
            entry_in = dn_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* src/top_k_score_table_with_ranks_unit.sv */
// Top-k score table: a chain of tkst_cell instances kept in descending score order.
// The first word of a run is registered out of ST_EMIT, which follows ST_UPDATE; after it
// comes one word per cycle. busy stays high through ST_UPDATE and ST_EMIT, so a new request
// is taken only once the control is back in idle. ST_EMIT rotates the whole chain once past
// the head cell, and the receiver cannot stall the run.
// Synchronous active-high reset empties the table and returns the control to idle.
module top_k_score_table_with_ranks_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_score,
   input  logic [31:0] req_name_tag,
   output logic        rsp_strobe,
   output logic        rsp_entry_valid,
   output logic [5:0]  rsp_position,
   output logic [6:0]  rsp_rank,
   output logic [15:0] rsp_entry_score,
   output logic [31:0] rsp_entry_name,
   output logic        rsp_accepted,
   output logic        rsp_last
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          req_type_ff, req_type_in;
   tkst_pkg::entry_type req_entry_ff, req_entry_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                acc_ff, acc_in;
   logic [15:0]         prev_score_ff, prev_score_in;
   logic [6:0]          rank_ff, rank_in;
   logic                strobe_ff, strobe_in;
   logic                valid_ff, valid_in;
   logic [5:0]          pos_ff, pos_in;
   logic [15:0]         oscore_ff, oscore_in;
   logic [31:0]         oname_ff, oname_in;
   logic                last_ff, last_in;

   tkst_pkg::cell_op_type op;
   tkst_pkg::entry_type   entries [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] ge_vec;
   logic [TABLE_DEPTH-1:0] occ_vec;
   logic                   lower;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         assign occ_vec[g] = (CNT_W'(g) < count_ff);
         if (g == 0) begin : g_head
            tkst_cell u_cell (
               .clock     (clock),
               .op        (op),
               .new_entry (req_entry_ff),
               .up_entry  (req_entry_ff),
               .up_ge     (1'b1),
               .dn_entry  (entries[(g + 1) % TABLE_DEPTH]),
               .occupied  (occ_vec[g]),
               .entry     (entries[g]),
               .ge        (ge_vec[g])
            );
         end else begin : g_body
            tkst_cell u_cell (
               .clock     (clock),
               .op        (op),
               .new_entry (req_entry_ff),
               .up_entry  (entries[g - 1]),
               .up_ge     (ge_vec[g - 1]),
               .dn_entry  (entries[(g + 1) % TABLE_DEPTH]),
               .occupied  (occ_vec[g]),
               .entry     (entries[g]),
               .ge        (ge_vec[g])
            );
         end
      end
   endgenerate

   assign lower = |(occ_vec & ~ge_vec);
   assign busy  = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      req_entry_in  = req_entry_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      prev_score_in = prev_score_ff;
      rank_in       = rank_ff;
      strobe_in     = 1'b0;
      valid_in      = valid_ff;
      pos_in        = pos_ff;
      oscore_in     = oscore_ff;
      oname_in      = oname_ff;
      last_in       = last_ff;
      op            = tkst_pkg::CELL_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_type_in        = req_type;
               req_entry_in.score = req_score;
               req_entry_in.name  = req_name_tag;
               state_in           = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            acc_in   = 1'b0;
            idx_in   = '0;
            state_in = ST_EMIT;
            case (req_type_ff)
               tkst_pkg::REQ_LOAD: begin
                  if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                     op       = tkst_pkg::CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                     acc_in   = 1'b1;
                  end
               end
               tkst_pkg::REQ_OFFER: begin
                  if (lower) begin
                     op     = tkst_pkg::CELL_INSERT;
                     acc_in = 1'b1;
                  end
               end
               default: begin
                  op = tkst_pkg::CELL_HOLD;
               end
            endcase
         end
         ST_EMIT: begin
            op            = tkst_pkg::CELL_ROTATE;
            idx_in        = idx_ff + CNT_W'(1);
            prev_score_in = entries[0].score;
            if (idx_ff == '0 || entries[0].score != prev_score_ff) begin
               rank_in = 7'(idx_ff) + 7'd1;
            end
            strobe_in = (idx_ff < count_ff) || (count_ff == '0 && idx_ff == '0);
            valid_in  = (count_ff != '0);
            last_in   = (count_ff == '0) || (idx_ff == count_ff - CNT_W'(1));
            if (count_ff == '0) begin
               pos_in    = '0;
               rank_in   = '0;
               oscore_in = '0;
               oname_in  = '0;
            end else begin
               pos_in    = 6'(idx_ff);
               oscore_in = entries[0].score;
               oname_in  = entries[0].name;
            end
            if (idx_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         idx_ff    <= idx_in;
      end
      req_type_ff   <= req_type_in;
      req_entry_ff  <= req_entry_in;
      acc_ff        <= acc_in;
      prev_score_ff <= prev_score_in;
      rank_ff       <= rank_in;
      valid_ff      <= valid_in;
      pos_ff        <= pos_in;
      oscore_ff     <= oscore_in;
      oname_ff      <= oname_in;
      last_ff       <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_entry_valid = valid_ff;
   assign rsp_position    = pos_ff;
   assign rsp_rank        = rank_ff;
   assign rsp_entry_score = oscore_ff;
   assign rsp_entry_name  = oname_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_last        = last_ff;

endmodule

/* src/tkst_checker.sv */
// Port-level checks for the top-k score table and the bind that attaches them.
// It depends on the top level's port list only.
module tkst_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_entry_valid,
   input logic [5:0]  rsp_position,
   input logic [6:0]  rsp_rank,
   input logic        rsp_accepted,
   input logic        rsp_last
);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted request did not raise busy.");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_entry_valid |-> rsp_last && rsp_position == 6'd0)
      else $error("Empty-table word is not a lone final word at position zero.");

   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_entry_valid |->
         rsp_rank != 7'd0 && rsp_rank <= {1'b0, rsp_position} + 7'd1)
      else $error("Rank out of range for its position.");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=>
         rsp_strobe && rsp_position == $past(rsp_position) + 6'd1 &&
         rsp_accepted == $past(rsp_accepted))
      else $error("Run of words broken or out of order.");

endmodule

bind top_k_score_table_with_ranks_unit tkst_checker u_tkst_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_entry_valid (rsp_entry_valid),
   .rsp_position    (rsp_position),
   .rsp_rank        (rsp_rank),
   .rsp_accepted    (rsp_accepted),
   .rsp_last        (rsp_last)
);
